### rtl/core/ptdq_pkg.sv
// ----------------------------------------------------------------------------
// ptdq_pkg: shared types and constants for the periodic task delta timer queue
// Cell command encoding, controller states, op codes and small helpers.
// ----------------------------------------------------------------------------
package ptdq_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int DW            = 32;
   localparam int SW            = 3;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_SETD
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [SW-1:0]    slot;
      logic [DW-1:0]    delta;
   } cell_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_CHK,
      ST_RUN_ADJ,
      ST_POP,
      ST_RQ_NEXT,
      ST_STOP_FIND,
      ST_STOP_A,
      ST_STOP_B,
      ST_STOP_DEL,
      ST_ENQ_START,
      ST_ENQ_WALK,
      ST_ENQ_SETD,
      ST_ENQ_INS,
      ST_NULL
   } state_type;

   function automatic logic [DW-1:0] tick_len(input logic [3:0] t);
      logic [DW-1:0] r;
      r = DW'(1);
      if (t == 4'd2 || t == 4'd4 || t == 4'd8) begin
         r = DW'(t);
      end
      return r;
   endfunction

   function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
      logic [DW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DW] ? {DW{1'b1}} : s[DW-1:0];
   endfunction

endpackage

### rtl/core/ptdq_cell.sv
// ----------------------------------------------------------------------------
// ptdq_cell: one list position
// Holds a slot id and its relative delay; loads, shifts or edits on command.
// ----------------------------------------------------------------------------
module ptdq_cell #(
   parameter int IDX = 0,
   parameter int IW  = 3
) (
   input  logic                  clock,
   input  ptdq_pkg::cell_cmd_type cmd,
   input  logic [IW-1:0]         pos,
   input  logic [2:0]            left_slot,
   input  logic [31:0]           left_delta,
   input  logic [2:0]            right_slot,
   input  logic [31:0]           right_delta,
   output logic [2:0]            slot,
   output logic [31:0]           delta
);
   import ptdq_pkg::*;

   logic [SW-1:0] slot_ff, slot_in;
   logic [DW-1:0] delta_ff, delta_in;
   logic          at_pos, past_pos;

   assign at_pos   = (IW'(IDX) == pos);
   assign past_pos = (IW'(IDX) > pos);

   always_comb begin
      slot_in  = slot_ff;
      delta_in = delta_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (at_pos) begin
               slot_in  = cmd.slot;
               delta_in = cmd.delta;
            end else if (past_pos) begin
               slot_in  = left_slot;
               delta_in = left_delta;
            end
         end
         CELL_REMOVE: begin
            if (at_pos || past_pos) begin
               slot_in  = right_slot;
               delta_in = right_delta;
            end
         end
         CELL_SETD: begin
            if (at_pos) begin
               delta_in = cmd.delta;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      delta_ff <= delta_in;
   end

   assign slot  = slot_ff;
   assign delta = delta_ff;

endmodule

### rtl/core/ptdq_chain.sv
// ----------------------------------------------------------------------------
// ptdq_chain: row of list cells
// Position 0 is the head; offers head reads, one indexed read and slot lookup.
// ----------------------------------------------------------------------------
module ptdq_chain #(
   parameter int SLOTS = ptdq_pkg::SLOTS_DEFAULT,
   parameter int IW    = $clog2(SLOTS),
   parameter int CW    = $clog2(SLOTS + 1)
) (
   input  logic                   clock,
   input  ptdq_pkg::cell_cmd_type cmd,
   input  logic [IW-1:0]          pos,
   input  logic [IW-1:0]          rd_idx,
   input  logic [CW-1:0]          count,
   input  logic [2:0]             key,
   output logic [31:0]            rd_delta,
   output logic [31:0]            head_delta,
   output logic [31:0]            next_delta,
   output logic [2:0]             head_slot,
   output logic                   hit,
   output logic [IW-1:0]          hit_pos
);
   import ptdq_pkg::*;

   logic [SW-1:0] cslot  [SLOTS];
   logic [DW-1:0] cdelta [SLOTS];
   logic [SLOTS-1:0] match;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [SW-1:0] l_slot, r_slot;
      logic [DW-1:0] l_delta, r_delta;
      if (i > 0) begin : g_left
         assign l_slot  = cslot[i-1];
         assign l_delta = cdelta[i-1];
      end else begin : g_left0
         assign l_slot  = '0;
         assign l_delta = '0;
      end
      if (i < SLOTS - 1) begin : g_right
         assign r_slot  = cslot[i+1];
         assign r_delta = cdelta[i+1];
      end else begin : g_rightn
         assign r_slot  = '0;
         assign r_delta = '0;
      end
      ptdq_cell #(.IDX(i), .IW(IW)) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (pos),
         .left_slot   (l_slot),
         .left_delta  (l_delta),
         .right_slot  (r_slot),
         .right_delta (r_delta),
         .slot        (cslot[i]),
         .delta       (cdelta[i])
      );
      assign match[i] = (CW'(i) < count) && (cslot[i] == key);
   end

   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (match[i]) begin
            hit_pos = hit_pos | IW'(i);
         end
      end
   end

   assign hit        = |match;
   assign rd_delta   = cdelta[rd_idx];
   assign head_delta = cdelta[0];
   assign next_delta = cdelta[1];
   assign head_slot  = cslot[0];

endmodule

### rtl/core/periodic_task_delta_timer_queue.sv
// ----------------------------------------------------------------------------
// periodic_task_delta_timer_queue: delta-list scheduler for periodic tasks
// Sequencer over a row of list cells ordered by due time.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: op tick, add task to slot, or stop slot.
//   rsp_* returns the fired tasks of a tick in list order, last flagged on the
//   final one; a transaction that fires nothing returns one transaction with
//   rsp_fired_valid low and rsp_last high. csr_* sets the tick length.
// Sequencing:
//   One transaction is worked at a time; req_stall is high until it is done.
//   A tick checks the alarm only while one is armed; a stop looks up its
//   slot and removes it if it is queued. An add first runs the stop lookup
//   and removal, then walks the list to place the entry, with a delta fix
//   of the next entry when it lands inside the list. An expiring tick pops
//   the due entries, then runs one add walk per fired task to requeue it.
//   The walk of the insertion point moves one list position per cycle.
// Reset:
//   Synchronous; the list is empty, time and alarm are zero, tick length is 1.
// Stall:
//   rsp_* sits in an output register; while it is stalled the sequencer holds
//   before the next result, and the next request is taken once the last one
//   is registered.
// ----------------------------------------------------------------------------
module periodic_task_delta_timer_queue #(
   parameter int SLOTS = ptdq_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_slot,
   input  logic [31:0] req_start_delay,
   input  logic [31:0] req_interval,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_fired_valid,
   output logic [2:0]  rsp_fired_slot,
   output logic        rsp_last,
   output logic [31:0] rsp_system_time,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);
   import ptdq_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          is_add_ff, is_add_in;
   logic          requeue_ff, requeue_in;
   logic          popped_ff, popped_in;
   logic [IW-1:0] p_ff, p_in;
   logic [IW-1:0] k_ff, k_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] ins_d_ff, ins_d_in;
   logic [SW-1:0] ins_slot_ff, ins_slot_in;
   logic [DW-1:0] now_ff, now_in;
   logic [DW-1:0] at_arm_ff, at_arm_in;
   logic [DW-1:0] adly_ff, adly_in;
   logic [DW-1:0] acnt_ff, acnt_in;
   logic [3:0]    tick_ff;
   logic [DW-1:0] period_ff [SLOTS];
   logic [SW-1:0] fq_ff [SLOTS];
   logic [CW-1:0] fq_cnt_ff, fq_cnt_in;
   logic          fq_push, fq_pop, period_we;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_fv_ff, rsp_fv_in;
   logic [SW-1:0] rsp_slot_ff, rsp_slot_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [DW-1:0] rsp_time_ff, rsp_time_in;

   cell_cmd_type  cmd;
   logic [IW-1:0] pos, rd_idx, hit_pos;
   logic [DW-1:0] rd_delta, head_delta, next_delta;
   logic [SW-1:0] head_slot;
   logic          hit;

   logic          in_take, slot_ok, emit_ok, pop_cond, has_next_p, front;
   logic [DW-1:0] elapsed, head_rem, head_adj, stop_sum, tlen;

   assign req_stall  = (state_ff != ST_IDLE);
   assign in_take    = req_valid && (state_ff == ST_IDLE);
   assign slot_ok    = (int'(req_slot) < SLOTS);
   assign emit_ok    = !rsp_valid_ff || !rsp_stall;
   assign pop_cond   = (count_ff != '0) && (head_delta == '0);
   assign has_next_p = ((CW'(p_ff) + CW'(1)) < count_ff);
   assign front      = (count_ff == '0) || (ins_d_ff < head_delta);
   assign elapsed    = now_ff - at_arm_ff;
   assign head_rem   = (elapsed > rd_delta) ? '0 : (rd_delta - elapsed);
   assign head_adj   = (elapsed >= head_delta) ? '0 : (head_delta - elapsed);
   assign stop_sum   = sat_add(rd_delta, rem_ff);
   assign tlen       = tick_len(tick_ff);
   assign period_we  = in_take && (req_op == OP_ADD) && slot_ok;

   always_comb begin
      unique case (state_ff)
         ST_STOP_A:   rd_idx = p_ff;
         ST_STOP_B:   rd_idx = p_ff + IW'(1);
         ST_ENQ_WALK,
         ST_ENQ_SETD: rd_idx = k_ff;
         default:     rd_idx = '0;
      endcase
   end

   ptdq_chain #(.SLOTS(SLOTS), .IW(IW), .CW(CW)) u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .pos        (pos),
      .rd_idx     (rd_idx),
      .count      (count_ff),
      .key        (slot_ff),
      .rd_delta   (rd_delta),
      .head_delta (head_delta),
      .next_delta (next_delta),
      .head_slot  (head_slot),
      .hit        (hit),
      .hit_pos    (hit_pos)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_take) begin
               unique case (req_op)
                  OP_TICK: state_in = (adly_ff != '0) ? ST_TICK_CHK : ST_NULL;
                  OP_ADD,
                  OP_STOP: state_in = slot_ok ? ST_STOP_FIND : ST_NULL;
                  default: state_in = ST_NULL;
               endcase
            end
         end
         ST_TICK_CHK:
            state_in = ((acnt_ff >= adly_ff) && (count_ff != '0)) ? ST_RUN_ADJ : ST_NULL;
         ST_RUN_ADJ: state_in = ST_POP;
         ST_POP: begin
            if (!pop_cond) begin
               state_in = popped_ff ? ST_RQ_NEXT : ST_NULL;
            end
         end
         ST_RQ_NEXT: state_in = (fq_cnt_ff != '0) ? ST_ENQ_START : ST_IDLE;
         ST_STOP_FIND: begin
            if (hit) begin
               state_in = ST_STOP_A;
            end else begin
               state_in = is_add_ff ? ST_ENQ_START : ST_NULL;
            end
         end
         ST_STOP_A:   state_in = has_next_p ? ST_STOP_B : ST_STOP_DEL;
         ST_STOP_B:   state_in = ST_STOP_DEL;
         ST_STOP_DEL: state_in = is_add_ff ? ST_ENQ_START : ST_NULL;
         ST_ENQ_START: state_in = front ? ST_ENQ_INS : ST_ENQ_WALK;
         ST_ENQ_WALK: begin
            if (CW'(k_ff) < count_ff) begin
               if (rd_delta > ins_d_ff) begin
                  state_in = ST_ENQ_SETD;
               end
            end else begin
               state_in = ST_ENQ_INS;
            end
         end
         ST_ENQ_SETD: state_in = ST_ENQ_INS;
         ST_ENQ_INS:  state_in = requeue_ff ? ST_RQ_NEXT : ST_NULL;
         ST_NULL:     state_in = emit_ok ? ST_IDLE : ST_NULL;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in    = count_ff;
      slot_in     = slot_ff;
      is_add_in   = is_add_ff;
      requeue_in  = requeue_ff;
      popped_in   = popped_ff;
      p_in        = p_ff;
      k_in        = k_ff;
      rem_in      = rem_ff;
      ins_d_in    = ins_d_ff;
      ins_slot_in = ins_slot_ff;
      now_in      = now_ff;
      at_arm_in   = at_arm_ff;
      adly_in     = adly_ff;
      acnt_in     = acnt_ff;
      fq_cnt_in   = fq_cnt_ff;
      fq_push     = 1'b0;
      fq_pop      = 1'b0;
      cmd.op      = CELL_HOLD;
      cmd.slot    = ins_slot_ff;
      cmd.delta   = ins_d_ff;
      pos         = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_fv_in   = rsp_fv_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_last_in = rsp_last_ff;
      rsp_time_in = rsp_time_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_take) begin
               requeue_in  = 1'b0;
               slot_in     = req_slot;
               is_add_in   = (req_op == OP_ADD);
               ins_slot_in = req_slot;
               if (req_start_delay != '0) begin
                  ins_d_in = req_start_delay;
               end else if (req_interval != '0) begin
                  ins_d_in = req_interval;
               end else begin
                  ins_d_in = DW'(1);
               end
               if (req_op == OP_TICK) begin
                  now_in = now_ff + tlen;
                  if (adly_ff != '0) begin
                     acnt_in = acnt_ff + tlen;
                  end
               end
            end
         end
         ST_RUN_ADJ: begin
            cmd.op    = CELL_SETD;
            cmd.delta = head_adj;
            popped_in = 1'b0;
         end
         ST_POP: begin
            if (pop_cond) begin
               if (emit_ok) begin
                  cmd.op       = CELL_REMOVE;
                  count_in     = count_ff - CW'(1);
                  fq_push      = 1'b1;
                  fq_cnt_in    = fq_cnt_ff + CW'(1);
                  popped_in    = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_fv_in    = 1'b1;
                  rsp_slot_in  = head_slot;
                  rsp_last_in  = !((count_ff > CW'(1)) && (next_delta == '0));
                  rsp_time_in  = now_ff;
               end
            end else if (popped_ff && (count_ff != '0)) begin
               adly_in   = head_delta;
               acnt_in   = '0;
               at_arm_in = now_ff;
            end
         end
         ST_RQ_NEXT: begin
            if (fq_cnt_ff != '0) begin
               fq_pop      = 1'b1;
               fq_cnt_in   = fq_cnt_ff - CW'(1);
               ins_slot_in = fq_ff[0];
               ins_d_in    = period_ff[IW'(fq_ff[0])];
               requeue_in  = 1'b1;
            end
         end
         ST_STOP_FIND: begin
            p_in = hit_pos;
         end
         ST_STOP_A: begin
            rem_in = (p_ff == '0) ? head_rem : rd_delta;
         end
         ST_STOP_B: begin
            cmd.op    = CELL_SETD;
            cmd.delta = stop_sum;
            pos       = p_ff + IW'(1);
            if (p_ff == '0) begin
               adly_in   = stop_sum;
               acnt_in   = '0;
               at_arm_in = now_ff;
            end
         end
         ST_STOP_DEL: begin
            cmd.op   = CELL_REMOVE;
            pos      = p_ff;
            count_in = count_ff - CW'(1);
         end
         ST_ENQ_START: begin
            if (front) begin
               if (count_ff != '0) begin
                  cmd.op    = CELL_SETD;
                  cmd.delta = head_delta - ins_d_ff;
               end
               adly_in   = ins_d_ff;
               acnt_in   = '0;
               at_arm_in = now_ff;
               k_in      = '0;
            end else begin
               ins_d_in = ins_d_ff - head_delta;
               k_in     = IW'(1);
            end
         end
         ST_ENQ_WALK: begin
            if ((CW'(k_ff) < count_ff) && !(rd_delta > ins_d_ff)) begin
               ins_d_in = ins_d_ff - rd_delta;
               k_in     = k_ff + IW'(1);
            end
         end
         ST_ENQ_SETD: begin
            cmd.op    = CELL_SETD;
            cmd.delta = rd_delta - ins_d_ff;
            pos       = k_ff;
         end
         ST_ENQ_INS: begin
            cmd.op   = CELL_INSERT;
            pos      = k_ff;
            count_in = count_ff + CW'(1);
         end
         ST_NULL: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_fv_in    = 1'b0;
               rsp_slot_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_time_in  = now_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fq_cnt_ff    <= '0;
         popped_ff    <= 1'b0;
         requeue_ff   <= 1'b0;
         is_add_ff    <= 1'b0;
         now_ff       <= '0;
         at_arm_ff    <= '0;
         adly_ff      <= '0;
         acnt_ff      <= '0;
         tick_ff      <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fq_cnt_ff    <= fq_cnt_in;
         popped_ff    <= popped_in;
         requeue_ff   <= requeue_in;
         is_add_ff    <= is_add_in;
         now_ff       <= now_in;
         at_arm_ff    <= at_arm_in;
         adly_ff      <= adly_in;
         acnt_ff      <= acnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tick_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      ins_d_ff    <= ins_d_in;
      ins_slot_ff <= ins_slot_in;
      rsp_fv_ff   <= rsp_fv_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
      rsp_time_ff <= rsp_time_in;
      if (period_we) begin
         period_ff[IW'(req_slot)] <= (req_interval == '0) ? DW'(1) : req_interval;
      end
   end

   // fired queue: push at the fill mark, drain from the front
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (fq_pop) begin
            if (i < SLOTS - 1) begin
               fq_ff[i] <= fq_ff[i+1];
            end
         end else if (fq_push && (CW'(i) == fq_cnt_ff)) begin
            fq_ff[i] <= head_slot;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired_valid = rsp_fv_ff;
   assign rsp_fired_slot  = rsp_slot_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_system_time = rsp_time_ff;

endmodule

### rtl/core/ptdq_checker.sv
// ----------------------------------------------------------------------------
// ptdq_checker: port-level checks for the timer queue
// Watches the request and result channels; attached to the top by bind.
// ----------------------------------------------------------------------------
module ptdq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_fired_valid,
   input logic [2:0]  rsp_fired_slot,
   input logic        rsp_last,
   input logic [31:0] rsp_system_time
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fired_slot)
         && $stable(rsp_last) && $stable(rsp_system_time))
      else $error("result changed while stalled");

   // an empty result closes its request
   a_null_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired_valid |-> rsp_last && (rsp_fired_slot == 3'd0))
      else $error("empty result without last or with a slot");

   // an accepted request keeps the block busy for the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while work pending");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind periodic_task_delta_timer_queue ptdq_checker u_ptdq_checker (.*);
